@@ rtl/wtt_pkg.sv @@
// types, codes and constant tables for the waypoint then track steering core
`default_nettype none
package wtt_pkg;

    // item kinds on the input channel
    localparam logic [1:0] FUNC_SUMMON = 2'd0;
    localparam logic [1:0] FUNC_DETECT = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_DRIVE_VEL  = 3'd0;
    localparam logic [2:0] CFG_SPEED_GAIN = 3'd1;
    localparam logic [2:0] CFG_TURN_GAIN  = 3'd2;
    localparam logic [2:0] CFG_TRANS_DIST = 3'd3;
    localparam logic [2:0] CFG_STOP_DIST  = 3'd4;
    localparam logic [2:0] CFG_TGT_CLASS  = 3'd5;

    // fixed constants
    localparam logic [23:0]        RANGE_RESET = 24'd102400;
    localparam logic [23:0]        ONE_METRE   = 24'd1024;
    localparam logic [23:0]        DIST_MAX    = 24'd16777215;
    localparam logic signed [32:0] INV_GAIN    = 33'sd2608131496;
    localparam logic signed [32:0] PI_Q16      = 33'sd205887;
    localparam int                 ATAN_DEPTH  = 24;

    typedef enum logic [3:0] {
        S_IDLE, S_CORD, S_MAG, S_MAGW, S_SPD, S_SPDW,
        S_TRN2, S_TRN3, S_TRK, S_TRKW, S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [23:0] target_x;
        logic signed [23:0] target_y;
        logic [7:0]         det_class;
        logic signed [23:0] det_lateral;
        logic [22:0]        det_range;
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic [15:0]        pose_heading;
        logic signed [15:0] cmd_velocity;
        logic signed [15:0] cmd_turn;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] out_velocity;
        logic signed [15:0] out_turn;
        logic [1:0]         mode;
        logic               arrived;
        logic [23:0]        waypoint_distance;
        logic [15:0]        bearing;
    } t_out_beat;

    // cordic arctangent table, 2^-32 turns
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // saturate a wide signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [66:0] v);
        logic signed [15:0] r;
        if (v > 67'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -67'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/waypoint_then_track_steering_core.sv @@
// Summon and detection beats give no result.
// A tick in path mode runs CORDIC_STEPS (capped at 24) cordic iterations and then uses
// the shared multiplier, which alone serves it when the goal sits at the pose; a tick
// without path goes to tracking or to the result, and waits while the output register is stalled.
// One item at a time; input stall is high until the result sits in the output register.
// Reset (synchronous, active low) clears modes, goal and kept detection, restores config.
`default_nettype none
module waypoint_then_track_steering_core
    import wtt_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire t_in_beat    i_in_data,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_beat        o_out_data,
    input  wire logic        i_out_stall,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [22:0] i_cfg_data
);

    localparam int NSTEP = (CORDIC_STEPS > ATAN_DEPTH) ? ATAN_DEPTH : CORDIC_STEPS;

    // configuration registers
    logic [14:0] r_drive;
    logic [15:0] r_speed_gain, r_turn_gain;
    logic [22:0] r_trans_dist, r_stop_dist;
    logic [7:0]  r_tgt_class;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive      <= 15'd256;
            r_speed_gain <= 16'd256;
            r_turn_gain  <= 16'd256;
            r_trans_dist <= 23'd5120;
            r_stop_dist  <= 23'd1024;
            r_tgt_class  <= 8'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DRIVE_VEL:  r_drive      <= i_cfg_data[14:0];
                CFG_SPEED_GAIN: r_speed_gain <= i_cfg_data[15:0];
                CFG_TURN_GAIN:  r_turn_gain  <= i_cfg_data[15:0];
                CFG_TRANS_DIST: r_trans_dist <= i_cfg_data;
                CFG_STOP_DIST:  r_stop_dist  <= i_cfg_data;
                CFG_TGT_CLASS:  r_tgt_class  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    t_state             r_state, n_state;
    logic               r_pending, n_pending, r_path, n_path, r_track, n_track;
    logic               r_arrived, n_arrived;
    logic signed [23:0] r_goal_x, n_goal_x, r_goal_y, n_goal_y;
    logic [23:0]        r_best_range, n_best_range;
    logic signed [23:0] r_best_lat, n_best_lat;
    logic [23:0]        r_last_dist, n_last_dist;
    logic [15:0]        r_last_bear, n_last_bear;
    logic [15:0]        r_heading, n_heading;
    logic signed [15:0] r_vel, n_vel, r_turn, n_turn;
    logic signed [31:0] r_x, n_x, r_y, n_y;
    logic [31:0]        r_z, n_z;
    logic [4:0]         r_iter, n_iter;
    logic signed [66:0] r_prod;
    logic               r_out_valid, n_out_valid;
    t_out_beat          r_out, n_out;

    // shared multiplier operands
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;

    logic signed [24:0] t_dx, t_dy;
    logic signed [31:0] t_x0, t_y0, t_xs, t_ys;
    logic signed [66:0] t_wide;
    logic signed [15:0] t_err;
    logic               t_handover;

    // next state and datapath
    always_comb begin
        n_state = r_state;  n_pending = r_pending; n_path = r_path; n_track = r_track;
        n_arrived = r_arrived; n_goal_x = r_goal_x; n_goal_y = r_goal_y;
        n_best_range = r_best_range; n_best_lat = r_best_lat;
        n_last_dist = r_last_dist; n_last_bear = r_last_bear; n_heading = r_heading;
        n_vel = r_vel; n_turn = r_turn; n_x = r_x; n_y = r_y; n_z = r_z;
        n_iter = r_iter; n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        mul_a = '0;
        mul_b = '0;
        t_dx = 25'(r_goal_x) - 25'(i_in_data.pose_x);
        t_dy = 25'(r_goal_y) - 25'(i_in_data.pose_y);
        t_x0 = 32'(t_dx) <<< 4;
        t_y0 = 32'(t_dy) <<< 4;
        t_xs = r_x >>> r_iter;
        t_ys = r_y >>> r_iter;
        t_wide = '0;
        t_err = $signed(r_last_bear - r_heading);
        t_handover = 1'b0;
        o_in_stall = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    priority case (i_in_data.func)
                        FUNC_SUMMON: begin
                            n_goal_x  = i_in_data.target_x;
                            n_goal_y  = i_in_data.target_y;
                            n_pending = 1'b1;
                        end
                        FUNC_DETECT: begin
                            if (i_in_data.det_class == r_tgt_class &&
                                {1'b0, i_in_data.det_range} < r_best_range) begin
                                n_best_range = {1'b0, i_in_data.det_range};
                                n_best_lat   = i_in_data.det_lateral;
                            end
                        end
                        FUNC_TICK: begin
                            n_heading = i_in_data.pose_heading;
                            n_vel     = i_in_data.cmd_velocity;
                            n_turn    = i_in_data.cmd_turn;
                            n_arrived = 1'b0;
                            n_pending = 1'b0;
                            n_path    = r_path || r_pending;
                            if (r_path || r_pending) begin
                                if (t_dx == 25'sd0 && t_dy == 25'sd0) begin
                                    n_last_dist = '0;
                                    n_last_bear = '0;
                                    n_state     = S_SPD;
                                end else begin
                                    // fold into the right half plane
                                    n_x     = (t_x0 < 0) ? -t_x0 : t_x0;
                                    n_y     = (t_x0 < 0) ? -t_y0 : t_y0;
                                    n_z     = (t_x0 < 0) ? 32'h80000000 : 32'h0;
                                    n_iter  = '0;
                                    n_state = S_CORD;
                                end
                            end else if (r_track) begin
                                n_state = S_TRK;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // one vectoring iteration a cycle
            S_CORD: begin
                if (r_y >= 0) begin
                    n_x = r_x + t_ys;
                    n_y = r_y - t_xs;
                    n_z = r_z + atan_turn(r_iter);
                end else begin
                    n_x = r_x - t_ys;
                    n_y = r_y + t_xs;
                    n_z = r_z - atan_turn(r_iter);
                end
                if (r_iter == 5'(NSTEP - 1)) begin
                    n_state = S_MAG;
                end else begin
                    n_iter = r_iter + 5'd1;
                end
            end
            S_MAG: begin
                mul_a   = 34'(r_x);
                mul_b   = INV_GAIN;
                n_state = S_MAGW;
            end
            // gain-corrected magnitude and rounded bearing
            S_MAGW: begin
                t_wide = (r_prod + 67'sd34359738368) >>> 36;
                if (t_wide < 0) begin
                    n_last_dist = '0;
                end else if (t_wide > $signed(67'(DIST_MAX))) begin
                    n_last_dist = DIST_MAX;
                end else begin
                    n_last_dist = t_wide[23:0];
                end
                n_last_bear = 16'((r_z + 32'h8000) >> 16);
                n_state     = S_SPD;
            end
            S_SPD: begin
                mul_a   = {10'b0, r_last_dist};
                mul_b   = {17'b0, r_speed_gain};
                n_state = S_SPDW;
            end
            // speed clamp, then heading error times gain
            S_SPDW: begin
                t_wide = r_prod >>> 10;
                if (t_wide > $signed(67'(r_drive))) begin
                    n_vel = {1'b0, r_drive};
                end else begin
                    n_vel = t_wide[15:0];
                end
                mul_a   = 34'(t_err);
                mul_b   = {17'b0, r_turn_gain};
                n_state = S_TRN2;
            end
            S_TRN2: begin
                mul_a   = r_prod[33:0];
                mul_b   = PI_Q16;
                n_state = S_TRN3;
            end
            // path turn and hand-over to tracking
            S_TRN3: begin
                n_turn = sat16((r_prod + 67'sd1073741824) >>> 31);
                t_handover = (r_last_dist < {1'b0, r_trans_dist} &&
                              r_best_range < {1'b0, r_trans_dist}) ||
                             r_last_dist < ONE_METRE;
                if (t_handover) begin
                    n_path   = 1'b0;
                    n_goal_x = '0;
                    n_goal_y = '0;
                    n_track  = 1'b1;
                end
                n_state = (t_handover || r_track) ? S_TRK : S_DONE;
            end
            S_TRK: begin
                mul_a   = 34'(r_best_lat);
                mul_b   = {17'b0, r_turn_gain};
                n_state = S_TRKW;
            end
            S_TRKW: begin
                if (r_best_range < {1'b0, r_stop_dist}) begin
                    n_track   = 1'b0;
                    n_arrived = 1'b1;
                end
                n_vel   = {1'b0, r_drive};
                n_turn  = sat16(r_prod >>> 10);
                n_state = S_DONE;
            end
            // hand the result to the output register
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.out_velocity      = r_vel;
                    n_out.out_turn          = r_turn;
                    n_out.mode              = {r_track, r_path};
                    n_out.arrived           = r_arrived;
                    n_out.waypoint_distance = r_last_dist;
                    n_out.bearing           = r_last_bear;
                    n_out_valid             = 1'b1;
                    n_best_range            = RANGE_RESET;
                    n_best_lat              = '0;
                    n_state                 = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pending    <= 1'b0;
            r_path       <= 1'b0;
            r_track      <= 1'b0;
            r_arrived    <= 1'b0;
            r_goal_x     <= '0;
            r_goal_y     <= '0;
            r_best_range <= RANGE_RESET;
            r_best_lat   <= '0;
            r_last_dist  <= '0;
            r_last_bear  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pending    <= n_pending;
            r_path       <= n_path;
            r_track      <= n_track;
            r_arrived    <= n_arrived;
            r_goal_x     <= n_goal_x;
            r_goal_y     <= n_goal_y;
            r_best_range <= n_best_range;
            r_best_lat   <= n_best_lat;
            r_last_dist  <= n_last_dist;
            r_last_bear  <= n_last_bear;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers and the shared multiplier
    always_ff @(posedge i_clk) begin
        r_heading <= n_heading;
        r_vel     <= n_vel;
        r_turn    <= n_turn;
        r_x       <= n_x;
        r_y       <= n_y;
        r_z       <= n_z;
        r_iter    <= n_iter;
        r_out     <= n_out;
        r_prod    <= mul_a * mul_b;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_arrived_clears_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.arrived |-> !o_out_data.mode[1])
        else $error("arrived with tracking still set");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CORD |-> r_iter < 5'(NSTEP))
        else $error("cordic step count out of range");
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result without a finished tick");
    a_cordic_to_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MAG |-> $past(r_state) == S_CORD)
        else $error("magnitude step not after cordic");

endmodule
`default_nettype wire

@@ test/tb_waypoint_then_track_steering_core.sv @@
// testbench for the waypoint then track steering core: directed and random beats
`timescale 1ns / 100ps
module tb_waypoint_then_track_steering_core;
    import wtt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    t_in_beat    i_in_data;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_beat   o_out_data;
    logic        i_out_stall;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [22:0] i_cfg_data;

    waypoint_then_track_steering_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_out_data(o_out_data), .i_out_stall(i_out_stall),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    localparam int CYCLE_LIMIT = 1500000;

    // steering state as the block should hold it
    logic [14:0] drive_vel;
    logic [15:0] spd_gain, trn_gain;
    logic [22:0] trans_dist, stop_dist;
    logic [7:0]  tgt_class;
    bit          pend, on_path, on_track;
    logic signed [23:0] goal_x, goal_y, keep_lat;
    logic [23:0] keep_rng, prev_dist;
    logic [15:0] prev_brg;

    t_out_beat cmd_q[$];
    int  n_err, n_ticks, n_arrive, n_sent, cyc;
    bit  busy_rx, hold_rx, quiet;
    int  hold_cnt;
    logic [31:0] atan_tab[24];

    initial begin
        atan_tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
            32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
            32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30,
            32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    end

    function automatic longint clip16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // distance and bearing from a 16-step vectoring pass
    task automatic range_bearing(input longint dx, input longint dy);
        longint x, y, xs, ys, m;
        logic [31:0] z;
        if (dx == 0 && dy == 0) begin
            prev_dist = 0;
            prev_brg = 0;
        end else begin
            x = dx * 16;
            y = dy * 16;
            z = 0;
            if (x < 0) begin
                x = -x; y = -y; z = 32'h80000000;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x += ys; y -= xs; z += atan_tab[i];
                end else begin
                    x -= ys; y += xs; z -= atan_tab[i];
                end
            end
            m = (x * 64'sd2608131496 + (64'sd1 <<< 35)) >>> 36;
            if (m < 0) m = 0;
            if (m > 16777215) m = 16777215;
            prev_dist = m[23:0];
            prev_brg = z[31:16] + {15'd0, z[15]};
        end
    endtask

    // apply one beat to the steering state, queue the command it causes
    task automatic steer_predict(input t_in_beat b);
        t_out_beat r;
        longint vel, trn, err, v;
        bit arr;
        arr = 0;
        if (b.func == FUNC_SUMMON) begin
            goal_x = b.target_x; goal_y = b.target_y; pend = 1;
        end else if (b.func == FUNC_DETECT) begin
            if (b.det_class == tgt_class && {1'b0, b.det_range} < keep_rng) begin
                keep_rng = {1'b0, b.det_range};
                keep_lat = b.det_lateral;
            end
        end else if (b.func == FUNC_TICK) begin
            vel = b.cmd_velocity;
            trn = b.cmd_turn;
            if (pend) begin
                pend = 0; on_path = 1;
            end
            if (on_path) begin
                range_bearing(longint'(goal_x) - longint'(b.pose_x),
                              longint'(goal_y) - longint'(b.pose_y));
                v = (longint'(prev_dist) * longint'(spd_gain)) >>> 10;
                if (v > drive_vel) v = drive_vel;
                vel = v;
                err = longint'($signed(prev_brg - b.pose_heading));
                trn = clip16((err * longint'(trn_gain) * 64'sd205887 + (64'sd1 <<< 30))
                             >>> 31);
                if ((prev_dist < trans_dist && keep_rng < trans_dist) || prev_dist < 1024) begin
                    on_path = 0; goal_x = 0; goal_y = 0; on_track = 1;
                end
            end
            if (on_track) begin
                if (keep_rng < stop_dist) begin
                    on_track = 0; arr = 1;
                end
                vel = drive_vel;
                trn = clip16((longint'(keep_lat) * longint'(trn_gain)) >>> 10);
            end
            keep_rng = RANGE_RESET;
            keep_lat = 0;
            r.out_velocity = vel[15:0];
            r.out_turn = trn[15:0];
            r.mode = {on_track, on_path};
            r.arrived = arr;
            r.waypoint_distance = prev_dist;
            r.bearing = prev_brg;
            cmd_q.push_back(r);
        end
    endtask

    // clock and cycle limit
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end
    initial begin
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc > CYCLE_LIMIT) begin
                $display("timeout at %0t", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver stall: random, quiet stretch, or long hold-off
    initial begin
        i_out_stall = 1;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_out_stall <= 1;
                hold_cnt++;
                if (hold_cnt > 400) hold_rx = 0;
            end else if (busy_rx) begin
                i_out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 36);
            end else begin
                i_out_stall <= 0;
            end
        end
    end

    // result checker
    initial begin
        t_out_beat e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                if (cmd_q.size() == 0) begin
                    $display("%0t unexpected beat %h", $time, o_out_data);
                    n_err++;
                end else begin
                    e = cmd_q.pop_front();
                    n_ticks++;
                    if (e.arrived) n_arrive++;
                    if (e.out_velocity !== o_out_data.out_velocity)
                        $display("%0t velocity exp %0d got %0d", $time,
                                 e.out_velocity, o_out_data.out_velocity);
                    if (e.out_turn !== o_out_data.out_turn)
                        $display("%0t turn exp %0d got %0d", $time,
                                 e.out_turn, o_out_data.out_turn);
                    if (e.mode !== o_out_data.mode)
                        $display("%0t mode exp %0d got %0d", $time, e.mode, o_out_data.mode);
                    if (e.arrived !== o_out_data.arrived)
                        $display("%0t arrived exp %0d got %0d", $time,
                                 e.arrived, o_out_data.arrived);
                    if (e.waypoint_distance !== o_out_data.waypoint_distance)
                        $display("%0t distance exp %0d got %0d", $time,
                                 e.waypoint_distance, o_out_data.waypoint_distance);
                    if (e.bearing !== o_out_data.bearing)
                        $display("%0t bearing exp %0d got %0d", $time,
                                 e.bearing, o_out_data.bearing);
                    if (e !== o_out_data) n_err++;
                end
            end
        end
    end

    // send one beat, with optional idle cycles before it
    task automatic send_beat(input t_in_beat b);
        if (!quiet) begin
            while ($urandom_range(99) < 36) begin
                i_in_valid <= 0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1;
        i_in_data <= b;
        steer_predict(b);
        n_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [22:0] val);
        i_cfg_wr_en <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        case (idx)
            CFG_DRIVE_VEL:  drive_vel = val[14:0];
            CFG_SPEED_GAIN: spd_gain = val[15:0];
            CFG_TURN_GAIN:  trn_gain = val[15:0];
            CFG_TRANS_DIST: trans_dist = val;
            CFG_STOP_DIST:  stop_dist = val;
            CFG_TGT_CLASS:  tgt_class = val[7:0];
            default: ;
        endcase
    endtask

    function automatic t_in_beat rand_beat(input logic [1:0] f);
        t_in_beat b;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(t_in_beat)-1:0];
        b.func = f;
        return b;
    endfunction

    function automatic t_in_beat summon_at(input int x, input int y);
        t_in_beat b;
        b = rand_beat(FUNC_SUMMON);
        b.target_x = 24'(x); b.target_y = 24'(y);
        return b;
    endfunction

    function automatic t_in_beat detect(input logic [7:0] c, input int r, input int lat);
        t_in_beat b;
        b = rand_beat(FUNC_DETECT);
        b.det_class = c; b.det_range = 23'(r); b.det_lateral = 24'(lat);
        return b;
    endfunction

    function automatic t_in_beat tick_at(input int x, input int y, input logic [15:0] h);
        t_in_beat b;
        b = rand_beat(FUNC_TICK);
        b.pose_x = 24'(x); b.pose_y = 24'(y); b.pose_heading = h;
        return b;
    endfunction

    // extremes, every kind, ties, half-turn error, goal at pose, unknown kind
    task automatic test_directed();
        t_in_beat b;
        send_beat(tick_at(0, 0, 0));
        b = tick_at(0, 0, 0); b.cmd_velocity = 16'sh8000; b.cmd_turn = 16'sh7FFF;
        send_beat(b);
        send_beat(summon_at(0, 0));
        send_beat(tick_at(0, 0, 0));
        send_beat(tick_at(0, 0, 0));
        send_beat(summon_at(-8388608, 8388607));
        send_beat(tick_at(8388607, -8388608, 16'hFFFF));
        send_beat(summon_at(-100000, 0));
        send_beat(tick_at(0, 0, 0));
        send_beat(tick_at(0, 0, 16'h8000));
        send_beat(detect(0, 4000, 5000));
        send_beat(detect(0, 4000, -5000));
        send_beat(detect(1, 10, 7));
        send_beat(tick_at(-97000, 0, 16'h8000));
        send_beat(detect(0, 0, -8388608));
        send_beat(tick_at(0, 0, 0));
        b = rand_beat(2'd3);
        send_beat(b);
        send_beat(detect(0, 8388607, 8388607));
        send_beat(tick_at(0, 0, 0));
        drain();
    endtask

    // random missions: summon, approach ticks with detections, noise
    task automatic test_random(input int count);
        t_in_beat b;
        int gx, gy, px, py, k;
        k = 0;
        while (k < count) begin
            gx = $signed($urandom_range(40000)) - 20000;
            gy = $signed($urandom_range(40000)) - 20000;
            px = 0; py = 0;
            send_beat(summon_at(gx, gy)); k++;
            for (int s = 0; s < 12 && k < count; s++) begin
                if ($urandom_range(3) == 0) begin
                    send_beat(rand_beat(2'($urandom_range(3)))); k++;
                end
                if ($urandom_range(1)) begin
                    send_beat(detect($urandom_range(1) ? tgt_class : 8'($urandom),
                                     $urandom_range(8000), $signed($urandom) >>> 12));
                    k++;
                end
                px = px + (gx - px) / 3;
                py = py + (gy - py) / 3;
                b = tick_at(px, py, 16'($urandom));
                send_beat(b); k++;
            end
        end
    endtask

    // long receiver hold-off while beats keep coming, then sender pause
    task automatic test_backpressure();
        hold_cnt = 0;
        hold_rx = 1;
        test_random(40);
        i_in_valid <= 0;
        while (hold_rx) @(posedge i_clk);
        drain();
    endtask

    task automatic set_all(input logic [22:0] v0, v1, v2, v3, v4, v5);
        write_reg(CFG_DRIVE_VEL, v0);
        write_reg(CFG_SPEED_GAIN, v1);
        write_reg(CFG_TURN_GAIN, v2);
        write_reg(CFG_TRANS_DIST, v3);
        write_reg(CFG_STOP_DIST, v4);
        write_reg(CFG_TGT_CLASS, v5);
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_in_data = '0;
        i_cfg_wr_en = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        n_err = 0; n_ticks = 0; n_arrive = 0; n_sent = 0;
        busy_rx = 0; hold_rx = 0; quiet = 0;
        drive_vel = 256; spd_gain = 256; trn_gain = 256;
        trans_dist = 5120; stop_dist = 1024; tgt_class = 0;
        pend = 0; on_path = 0; on_track = 0;
        goal_x = 0; goal_y = 0; keep_lat = 0; keep_rng = RANGE_RESET;
        prev_dist = 0; prev_brg = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        busy_rx = 1;

        test_directed();
        set_all(23'h7FFF, 23'hFFFF, 23'hFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'hFF);
        test_directed();
        set_all(0, 0, 0, 0, 0, 0);
        test_random(150);
        drain();
        set_all(300, 600, 900, 6000, 1500, 3);
        test_random(500);
        drain();
        quiet = 1;
        test_random(300);
        drain();
        quiet = 0;
        test_backpressure();
        set_all(23'h7FFF, 23'hFFFF, 23'hFFFF, 20000, 3000, 0);
        test_random(500);
        drain();
        set_all(256, 256, 256, 5120, 1024, 0);
        test_random(300);
        drain();

        $display("sent %0d beats, checked %0d steering commands, %0d arrivals",
                 n_sent, n_ticks, n_arrive);
        $display("covered register extremes, missions, ties, and back-pressure");
        if (n_err == 0 && cmd_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/wtt_pkg.sv
rtl/waypoint_then_track_steering_core.sv
test/tb_waypoint_then_track_steering_core.sv
